// ----- hdl/pidst_pkg.sv -----
// ----------------------------------------------------------------------------
// pidst_pkg
// Shared types and constants for the position PID with settle timeout.
// ----------------------------------------------------------------------------
package pidst_pkg;

	localparam int GAIN_W     = 16;   // Q8.8 gains
	localparam int THR_W      = 25;   // large-error threshold
	localparam int TICK_W     = 16;   // settle tick count
	localparam int CMD_W      = 16;   // velocity command
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;
	localparam int FRAC_BITS  = 8;    // Q8.8 scaling

	localparam logic signed [GAIN_W-1:0] GAIN_P_RST       = 16'sd256;
	localparam logic signed [GAIN_W-1:0] GAIN_I_RST       = 16'sd0;
	localparam logic signed [GAIN_W-1:0] GAIN_D_RST       = 16'sd0;
	localparam logic signed [THR_W-1:0]  THRESHOLD_RST    = 25'sd0;
	localparam logic [TICK_W-1:0]        SETTLE_TICKS_RST = 16'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P       = 3'd0,
		CFG_GAIN_I       = 3'd1,
		CFG_GAIN_D       = 3'd2,
		CFG_THRESHOLD    = 3'd3,
		CFG_SETTLE_TICKS = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		REQ_SET_TARGET = 1'b0,
		REQ_TICK       = 1'b1
	} req_type_t;

endpackage

// ----- hdl/pidst_drive.sv -----
// ----------------------------------------------------------------------------
// pidst_drive
// Three gain products in one registered stage, then Q8.8 scaling with
// truncation toward zero and saturation to the command width.
// ----------------------------------------------------------------------------
module pidst_drive #(
	parameter int POS_BITS = 24,
	parameter int SUM_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   load,
	input  logic signed [pidst_pkg::GAIN_W-1:0]    gain_p,
	input  logic signed [pidst_pkg::GAIN_W-1:0]    gain_i,
	input  logic signed [pidst_pkg::GAIN_W-1:0]    gain_d,
	input  logic signed [POS_BITS:0]               err,
	input  logic signed [SUM_BITS-1:0]             err_sum,
	input  logic signed [POS_BITS+1:0]             err_diff,
	output logic signed [pidst_pkg::CMD_W-1:0]     cmd
);
	import pidst_pkg::*;

	localparam int DW = POS_BITS + 2;
	localparam int PW = ((SUM_BITS > DW) ? SUM_BITS : DW) + GAIN_W;
	localparam int AW = PW + 2;
	localparam int QW = AW - FRAC_BITS;

	localparam logic signed [QW-1:0] CMD_HI = QW'({1'b0, {(CMD_W-1){1'b1}}});
	localparam logic signed [QW-1:0] CMD_LO = ~CMD_HI;

	logic signed [PW-1:0] prod_p_s3;
	logic signed [PW-1:0] prod_i_s3;
	logic signed [PW-1:0] prod_d_s3;
	logic signed [AW-1:0] acc;
	logic signed [QW-1:0] quo;
	logic signed [QW-1:0] quo_tz;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_p_s3 <= PW'(gain_p) * PW'(err);
			prod_i_s3 <= PW'(gain_i) * PW'(err_sum);
			prod_d_s3 <= PW'(gain_d) * PW'(err_diff);
		end
	end

	always_comb begin
		acc = AW'(prod_p_s3) + AW'(prod_i_s3) + AW'(prod_d_s3);
		quo = acc[AW-1:FRAC_BITS];
		// arithmetic shift floors; bump negative inexact values back toward zero
		if (acc[AW-1] && (acc[FRAC_BITS-1:0] != '0)) begin
			quo_tz = quo + QW'(1);
		end else begin
			quo_tz = quo;
		end
		if (quo_tz > CMD_HI) begin
			cmd = CMD_HI[CMD_W-1:0];
		end else if (quo_tz < CMD_LO) begin
			cmd = CMD_LO[CMD_W-1:0];
		end else begin
			cmd = quo_tz[CMD_W-1:0];
		end
	end

endmodule

// ----- hdl/position_pid_with_settle_timeout_unit.sv -----
// ----------------------------------------------------------------------------
// position_pid_with_settle_timeout_unit
// Pipeline: a result passes from its input transfer through
//   input reg s1 -> state update s2 -> gain products s3 -> output reg.
// Throughput: one item per cycle unless out_ready back-pressure stalls;
//   the only loop is the s1 state update (error, threshold compare, integral add).
// Reset (arst_n low): loop disarmed, integral, previous error, target and
//   settle count cleared, registers back to defaults, pipeline empty.
// ----------------------------------------------------------------------------
module position_pid_with_settle_timeout_unit #(
	parameter int POS_BITS = 24,
	parameter int SUM_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [pidst_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pidst_pkg::CFG_DATA_W-1:0]      cfg_data,
	// request channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  req_type,
	input  logic signed [POS_BITS-1:0]            target_pos,
	input  logic signed [POS_BITS-1:0]            sensor_pos,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  drive_valid,
	output logic signed [pidst_pkg::CMD_W-1:0]    velocity_cmd,
	output logic                                  loop_armed
);
	import pidst_pkg::*;

	// error is one bit wider than a position, its difference one more
	localparam int EW = POS_BITS + 1;
	localparam int DW = POS_BITS + 2;
	localparam int CW = (EW > THR_W) ? EW : THR_W;
	localparam int SW = ((SUM_BITS > EW) ? SUM_BITS : EW) + 1;

	localparam logic signed [SW-1:0] SUM_HI = SW'({1'b0, {(SUM_BITS-1){1'b1}}});
	localparam logic signed [SW-1:0] SUM_LO = ~SUM_HI;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic signed [THR_W-1:0]  threshold_q;
	logic [TICK_W-1:0]        settle_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q       <= GAIN_P_RST;
			gain_i_q       <= GAIN_I_RST;
			gain_d_q       <= GAIN_D_RST;
			threshold_q    <= THRESHOLD_RST;
			settle_ticks_q <= SETTLE_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GAIN_P:       gain_p_q       <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_I:       gain_i_q       <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_D:       gain_d_q       <= cfg_data[GAIN_W-1:0];
				CFG_THRESHOLD:    threshold_q    <= cfg_data[THR_W-1:0];
				CFG_SETTLE_TICKS: settle_ticks_q <= cfg_data[TICK_W-1:0];
				default: ;  // unmapped index: write dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline flow control. Each stage moves when the one after it has
	// room, so a result waiting in the output register never blocks the
	// stages behind it until they have all filled.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic out_adv, rdy_s3, rdy_s2, rdy_s1;
	logic mv_s1, mv_s2, mv_s3;

	assign out_adv = !out_valid_q || out_ready;
	assign rdy_s3  = !v_s3 || out_adv;
	assign rdy_s2  = !v_s2 || rdy_s3;
	assign rdy_s1  = !v_s1 || rdy_s2;
	assign mv_s3   = v_s3 && out_adv;
	assign mv_s2   = v_s2 && rdy_s3;
	assign mv_s1   = v_s1 && rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1        <= in_valid;
			if (rdy_s2)  v_s2        <= mv_s1;
			if (rdy_s3)  v_s3        <= mv_s2;
			if (out_adv) out_valid_q <= mv_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register
	// ------------------------------------------------------------------
	logic                       req_type_s1;
	logic signed [POS_BITS-1:0] target_s1, sensor_s1;

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			req_type_s1 <= req_type;
			target_s1   <= target_pos;
			sensor_s1   <= sensor_pos;
		end
	end

	// ------------------------------------------------------------------
	// Loop state and its update. The state advances when the item in s1
	// moves on, so the next item sees it in the following cycle.
	// ------------------------------------------------------------------
	logic                       armed_q;
	logic signed [POS_BITS-1:0] target_q;
	logic signed [SUM_BITS-1:0] error_sum_q;
	logic signed [EW-1:0]       prev_error_q;
	logic [TICK_W-1:0]          settle_count_q;

	logic                       is_set, tick_live, above, drive, settle_done;
	logic signed [EW-1:0]       err;
	logic signed [DW-1:0]       err_diff;
	logic signed [SW-1:0]       sum_wide;
	logic signed [SUM_BITS-1:0] sum_sat;
	logic                       armed_nx;

	always_comb begin
		is_set    = (req_type_t'(req_type_s1) == REQ_SET_TARGET);
		tick_live = !is_set && armed_q;
		err       = EW'(sensor_s1) - EW'(target_q);
		err_diff  = DW'(err) - DW'(prev_error_q);
		above     = CW'(err) > CW'(threshold_q);
		drive     = tick_live && above;
		settle_done = tick_live && !above && (settle_count_q >= settle_ticks_q);

		// saturating integral
		sum_wide = SW'(error_sum_q) + SW'(err);
		if (sum_wide > SUM_HI) begin
			sum_sat = SUM_HI[SUM_BITS-1:0];
		end else if (sum_wide < SUM_LO) begin
			sum_sat = SUM_LO[SUM_BITS-1:0];
		end else begin
			sum_sat = sum_wide[SUM_BITS-1:0];
		end

		if (is_set) begin
			armed_nx = 1'b1;
		end else if (settle_done) begin
			armed_nx = 1'b0;
		end else begin
			armed_nx = armed_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q        <= 1'b0;
			target_q       <= '0;
			error_sum_q    <= '0;
			prev_error_q   <= '0;
			settle_count_q <= '0;
		end else if (mv_s1) begin
			armed_q <= armed_nx;
			if (is_set) begin
				// settle count deliberately survives a new target
				target_q     <= target_s1;
				error_sum_q  <= '0;
				prev_error_q <= '0;
			end else if (drive) begin
				error_sum_q    <= sum_sat;
				prev_error_q   <= err;
				settle_count_q <= '0;
			end else if (settle_done) begin
				error_sum_q    <= '0;
				prev_error_q   <= '0;
				settle_count_q <= '0;
			end else if (tick_live) begin
				settle_count_q <= settle_count_q + TICK_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: operands for the products, taken with pre-update state
	// ------------------------------------------------------------------
	logic                       drive_s2, armed_s2;
	logic signed [EW-1:0]       err_s2;
	logic signed [SUM_BITS-1:0] sum_s2;
	logic signed [DW-1:0]       diff_s2;

	always_ff @(posedge clk) begin
		if (mv_s1) begin
			drive_s2 <= drive;
			armed_s2 <= armed_nx;
			err_s2   <= err;
			sum_s2   <= error_sum_q;
			diff_s2  <= err_diff;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: products (inside pidst_drive), scaled and saturated
	// ------------------------------------------------------------------
	logic                     drive_s3, armed_s3;
	logic signed [CMD_W-1:0]  cmd;

	always_ff @(posedge clk) begin
		if (mv_s2) begin
			drive_s3 <= drive_s2;
			armed_s3 <= armed_s2;
		end
	end

	pidst_drive #(
		.POS_BITS (POS_BITS),
		.SUM_BITS (SUM_BITS)
	) u_drive (
		.clk      (clk),
		.load     (mv_s2),
		.gain_p   (gain_p_q),
		.gain_i   (gain_i_q),
		.gain_d   (gain_d_q),
		.err      (err_s2),
		.err_sum  (sum_s2),
		.err_diff (diff_s2),
		.cmd      (cmd)
	);

	// ------------------------------------------------------------------
	// Output register: command forced to zero on non-drive results
	// ------------------------------------------------------------------
	logic                     drive_valid_q, loop_armed_q;
	logic signed [CMD_W-1:0]  velocity_cmd_q;

	always_ff @(posedge clk) begin
		if (mv_s3) begin
			drive_valid_q  <= drive_s3;
			loop_armed_q   <= armed_s3;
			velocity_cmd_q <= drive_s3 ? cmd : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign drive_valid  = drive_valid_q;
	assign loop_armed   = loop_armed_q;
	assign velocity_cmd = velocity_cmd_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_drive_implies_armed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_valid |-> loop_armed)
		else $error("drive result reported with loop disarmed");

	a_idle_cmd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drive_valid |-> velocity_cmd == '0)
		else $error("non-drive result carries a command");

	a_disarmed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> (error_sum_q == '0) && (prev_error_q == '0))
		else $error("integral or previous error left over while disarmed");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with an empty output register");

endmodule
